// ----- src/ccv_pkg.sv -----
package ccv_pkg;

  // Sequencer states of the top level
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_DOT0, ST_DOT1, ST_DOT2, ST_DOT3, ST_SCALE, ST_WGT,
    ST_PR0, ST_PR1, ST_PR2, ST_PR3,
    ST_RD, ST_WR,
    ST_GRD, ST_GLD, ST_GMIR, ST_GOUT,
    ST_FRD, ST_FLD, ST_FDEN, ST_FDIV, ST_FWAIT, ST_FWB
  } ccv_state_t;

  // Divider states
  typedef enum logic [1:0] {
    DV_IDLE, DV_PREP, DV_RUN
  } div_state_t;

  // Item actions
  localparam logic [1:0] ACT_BOUNDARY = 2'd0;
  localparam logic [1:0] ACT_INTERIOR = 2'd1;
  localparam logic [1:0] ACT_FINALIZE = 2'd2;
  localparam logic [1:0] ACT_GHOST    = 2'd3;

  // Register indexes
  localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [1:0] CFG_EPSILON    = 2'd1;

  // One cell store entry, Q32.32 accumulators
  typedef struct packed {
    logic signed [63:0] vol;
    logic signed [63:0] sz;
    logic signed [63:0] sy;
    logic signed [63:0] sx;
  } cell_entry_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  // Clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = v[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Add or subtract, clamped to the 64-bit signed range
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic sub);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    if (s[64] != s[63]) begin
      r = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // Q32.32 volume to unsigned Q16.16, clamped
  function automatic logic [31:0] vol_out(input logic signed [63:0] h);
    logic [47:0] s;
    logic [31:0] r;
    s = h[63:16];
    if (s[47]) begin
      r = 32'd0;
    end else if (|s[46:32]) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/ccv_ram.sv -----
module ccv_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ccv_div.sv -----
module ccv_div import ccv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_state_t         st_r, st_nxt;
  logic [63:0]        un_r, ud_r;
  logic               neg_r, zero_r, sat_r;
  logic [79:0]        rem_r;
  logic [93:0]        dsh_r;
  logic [30:0]        q_r;
  logic [4:0]         cnt_r;
  logic               done_r;
  logic               ge;
  logic signed [31:0] qs;

  assign ge = {14'd0, rem_r} >= dsh_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == DV_RUN) && (cnt_r == 5'd0);
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DV_IDLE: if (req.start) st_nxt = DV_PREP;
      DV_PREP: st_nxt = DV_RUN;
      DV_RUN:  if (cnt_r == 5'd0) st_nxt = DV_IDLE;
      default: st_nxt = DV_IDLE;
    endcase
  end

  // Restoring division, one quotient bit a cycle, bits 30 down to 0
  always_ff @(posedge clk) begin
    unique case (st_r)
      DV_IDLE: begin
        if (req.start) begin
          un_r   <= req.num[63] ? 64'(-req.num) : 64'(req.num);
          ud_r   <= req.den[63] ? 64'(-req.den) : 64'(req.den);
          neg_r  <= req.num[63] ^ req.den[63];
          zero_r <= req.den == 64'sd0;
        end
      end
      DV_PREP: begin
        sat_r <= {15'd0, un_r} >= {ud_r, 15'd0};
        rem_r <= {un_r, 16'd0};
        dsh_r <= {ud_r, 30'd0};
        q_r   <= '0;
        cnt_r <= 5'd30;
      end
      DV_RUN: begin
        if (ge) begin
          rem_r <= rem_r - dsh_r[79:0];
        end
        q_r   <= {q_r[29:0], ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      default: ;
    endcase
  end

  // Sign and clamp the quotient
  assign qs = $signed({1'b0, q_r});
  always_comb begin
    rsp.done = done_r;
    if (zero_r) begin
      rsp.quo = 32'sd0;
    end else if (sat_r) begin
      rsp.quo = neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp.quo = neg_r ? -qs : qs;
    end
  end

endmodule

// ----- src/cell_centroid_volume_2d_unit.sv -----
// Cell centroid and volume accumulator. After reset the block clears its cell
// store, one cell a cycle, with busy high. An item is taken on start while
// busy is low; busy then stays high until the item is done. Each boundary or
// interior face, and each ghost face whose area exceeds epsilon, runs its dot
// product and products through the single shared 33x33 multiplier; a finalize
// runs three divisions of the centroid sums through the bit-serial divider. A
// finalize or ghost item emits one beat on out_valid for one cycle as it
// completes; the beat must be taken then. An item naming a cell beyond the
// store is dropped.
module cell_centroid_volume_2d_unit import ccv_pkg::*; #(
  parameter int MAX_CELLS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [11:0]        in_left_cell,
  input  logic [11:0]        in_right_cell,
  input  logic [11:0]        in_face_number,
  input  logic signed [31:0] in_centre_x,
  input  logic signed [31:0] in_centre_y,
  input  logic signed [31:0] in_centre_z,
  input  logic signed [31:0] in_unit_normal_x,
  input  logic signed [31:0] in_unit_normal_y,
  input  logic signed [31:0] in_unit_normal_z,
  input  logic [31:0]        in_face_area,
  output logic               out_valid,
  output logic [12:0]        out_cell_index,
  output logic signed [31:0] out_centroid_x,
  output logic signed [31:0] out_centroid_y,
  output logic signed [31:0] out_centroid_z,
  output logic [31:0]        out_cell_volume,
  output logic               out_was_negative,
  output logic [12:0]        out_negative_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = $clog2(MAX_CELLS);

  ccv_state_t         state_r, state_nxt;
  logic [AW-1:0]      clr_r;
  logic [12:0]        cell_count_r;
  logic [15:0]        eps_r;
  logic [12:0]        neg_cnt_r;
  logic               out_valid_r;

  logic [1:0]         act_r;
  logic [11:0]        lc_r, rc_r, fn_r;
  logic signed [31:0] c_r [3];
  logic signed [31:0] n_r [3];
  logic [31:0]        area_r;
  logic               side_r;
  logic [1:0]         idx_r;
  logic signed [51:0] acc_r;
  logic signed [31:0] tmp_r;
  logic signed [63:0] pr_r [3];
  logic signed [31:0] src_r [3];
  logic signed [31:0] cen_r [3];
  logic [31:0]        vol_r;
  cell_entry_t        ent_r;
  logic signed [63:0] s1_r, den_r, h_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [49:0] prod_sh;
  logic [1:0]         k;
  logic               ghost, accept, lc_ok_in, rc_ok_in;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  cell_entry_t        ram_wdata, ram_q;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic               h_neg;
  logic signed [63:0] h_abs;
  logic [12:0]        neg_cnt_nxt;

  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign lc_ok_in  = {20'd0, in_left_cell} < 32'(MAX_CELLS);
  assign rc_ok_in  = {20'd0, in_right_cell} < 32'(MAX_CELLS);
  assign ghost     = act_r == ACT_GHOST;
  assign prod_sh   = $signed(prod_r[65:16]);
  assign h_neg     = h_r <= 64'sd0;
  assign h_abs     = h_neg ? -h_r : h_r;
  assign neg_cnt_nxt = (h_neg && neg_cnt_r != 13'h1FFF) ? neg_cnt_r + 13'd1 : neg_cnt_r;

  ccv_ram #(.WIDTH($bits(cell_entry_t)), .DEPTH(MAX_CELLS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  ccv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Lane of the dot product or product pass
  always_comb begin
    unique case (state_r)
      ST_DOT1, ST_PR1: k = 2'd1;
      ST_DOT2, ST_PR2: k = 2'd2;
      default:         k = 2'd0;
    endcase
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DOT0, ST_DOT1, ST_DOT2: begin
        mul_a = ghost ? 33'(src_r[k]) - 33'(c_r[k]) : 33'(c_r[k]);
        mul_b = 33'(n_r[k]);
      end
      ST_SCALE: begin
        mul_a = 33'(sat_s32(66'(acc_r)));
        mul_b = $signed({1'b0, area_r});
      end
      ST_PR0, ST_PR1, ST_PR2: begin
        mul_a = ghost ? 33'(n_r[k]) : 33'(c_r[k]);
        mul_b = 33'(tmp_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Store access and divider request
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(lc_r);
    ram_wdata = '0;
    ram_raddr = AW'(lc_r);
    dreq.start = state_r == ST_FDIV;
    dreq.den   = den_r;
    unique case (idx_r)
      2'd1:    dreq.num = ent_r.sy;
      2'd2:    dreq.num = ent_r.sz;
      default: dreq.num = ent_r.sx;
    endcase
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      ST_RD: ram_raddr = side_r ? AW'(rc_r) : AW'(lc_r);
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = side_r ? AW'(rc_r) : AW'(lc_r);
        ram_wdata.sx  = sat_add64(ram_q.sx, pr_r[0], side_r);
        ram_wdata.sy  = sat_add64(ram_q.sy, pr_r[1], side_r);
        ram_wdata.sz  = sat_add64(ram_q.sz, pr_r[2], side_r);
        ram_wdata.vol = sat_add64(ram_q.vol, $signed({{16{tmp_r[31]}}, tmp_r, 16'd0}),
                                  side_r);
      end
      ST_FWB: begin
        ram_we        = 1'b1;
        ram_wdata.sx  = $signed({{16{cen_r[0][31]}}, cen_r[0], 16'd0});
        ram_wdata.sy  = $signed({{16{cen_r[1][31]}}, cen_r[1], 16'd0});
        ram_wdata.sz  = $signed({{16{cen_r[2][31]}}, cen_r[2], 16'd0});
        ram_wdata.vol = h_abs;
      end
      default: ;
    endcase
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      cell_count_r <= 13'd0;
      eps_r        <= 16'd1;
      neg_cnt_r    <= 13'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == ST_GMIR || state_r == ST_GOUT || state_r == ST_FWB;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (state_r == ST_FWB) begin
        neg_cnt_r <= neg_cnt_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CELL_COUNT: cell_count_r <= cfg_data[12:0];
          CFG_EPSILON:    eps_r        <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(MAX_CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && lc_ok_in) begin
          unique case (in_action)
            ACT_BOUNDARY: state_nxt = ST_DOT0;
            ACT_INTERIOR: state_nxt = rc_ok_in ? ST_DOT0 : ST_IDLE;
            ACT_FINALIZE: state_nxt = ST_FRD;
            default:      state_nxt = ST_GRD;
          endcase
        end
      end
      ST_DOT0:  state_nxt = ST_DOT1;
      ST_DOT1:  state_nxt = ST_DOT2;
      ST_DOT2:  state_nxt = ST_DOT3;
      ST_DOT3:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ghost ? ST_PR0 : ST_WGT;
      ST_WGT:   state_nxt = ST_PR0;
      ST_PR0:   state_nxt = ST_PR1;
      ST_PR1:   state_nxt = ST_PR2;
      ST_PR2:   state_nxt = ST_PR3;
      ST_PR3:   state_nxt = ghost ? ST_GOUT : ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = (act_r == ACT_INTERIOR && !side_r) ? ST_RD : ST_IDLE;
      ST_GRD:   state_nxt = ST_GLD;
      ST_GLD:   state_nxt = (area_r > {16'd0, eps_r}) ? ST_DOT0 : ST_GMIR;
      ST_GMIR:  state_nxt = ST_IDLE;
      ST_GOUT:  state_nxt = ST_IDLE;
      ST_FRD:   state_nxt = ST_FLD;
      ST_FLD:   state_nxt = ST_FDEN;
      ST_FDEN:  state_nxt = ST_FDIV;
      ST_FDIV:  state_nxt = ST_FWAIT;
      ST_FWAIT: if (drsp.done) state_nxt = (idx_r == 2'd2) ? ST_FWB : ST_FDIV;
      ST_FWB:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        act_r  <= in_action;
        lc_r   <= in_left_cell;
        rc_r   <= in_right_cell;
        fn_r   <= in_face_number;
        c_r[0] <= in_centre_x;
        c_r[1] <= in_centre_y;
        c_r[2] <= in_centre_z;
        n_r[0] <= in_unit_normal_x;
        n_r[1] <= in_unit_normal_y;
        n_r[2] <= in_unit_normal_z;
        area_r <= in_face_area;
        side_r <= 1'b0;
      end
      ST_DOT1:  acc_r <= 52'(prod_sh);
      ST_DOT2, ST_DOT3: acc_r <= acc_r + 52'(prod_sh);
      ST_SCALE: if (ghost) tmp_r <= sat_s32(66'(acc_r) <<< 1);
      ST_WGT:   tmp_r <= sat_s32(66'(prod_sh));
      ST_PR1:   pr_r[0] <= prod_r[63:0];
      ST_PR2:   pr_r[1] <= prod_r[63:0];
      ST_PR3:   pr_r[2] <= prod_r[63:0];
      ST_WR:    side_r <= 1'b1;
      ST_GLD: begin
        src_r[0] <= sat_s32(66'($signed(ram_q.sx[63:16])));
        src_r[1] <= sat_s32(66'($signed(ram_q.sy[63:16])));
        src_r[2] <= sat_s32(66'($signed(ram_q.sz[63:16])));
        vol_r    <= vol_out(ram_q.vol);
      end
      ST_FLD: begin
        ent_r <= ram_q;
        s1_r  <= sat_add64(ram_q.vol, ram_q.vol >>> 1, 1'b0);
        h_r   <= ram_q.vol >>> 1;
      end
      ST_FDEN: begin
        den_r <= sat_add64(s1_r, $signed({16'd0, eps_r, 16'd0}), 1'b0);
        idx_r <= 2'd0;
      end
      ST_FWAIT: begin
        if (drsp.done) begin
          cen_r[idx_r] <= drsp.quo;
          idx_r        <= idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Result beat
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_GMIR, ST_GOUT: begin
        out_cell_index     <= 13'(fn_r) + cell_count_r;
        out_cell_volume    <= vol_r;
        out_was_negative   <= 1'b0;
        out_negative_total <= neg_cnt_r;
        if (state_r == ST_GMIR) begin
          out_centroid_x <= sat_s32((66'(c_r[0]) <<< 1) - 66'(src_r[0]));
          out_centroid_y <= sat_s32((66'(c_r[1]) <<< 1) - 66'(src_r[1]));
          out_centroid_z <= sat_s32((66'(c_r[2]) <<< 1) - 66'(src_r[2]));
        end else begin
          out_centroid_x <= sat_s32(66'(src_r[0]) - 66'($signed(pr_r[0][63:16])));
          out_centroid_y <= sat_s32(66'(src_r[1]) - 66'($signed(pr_r[1][63:16])));
          out_centroid_z <= sat_s32(66'(src_r[2]) - 66'($signed(pr_r[2][63:16])));
        end
      end
      ST_FWB: begin
        out_cell_index     <= 13'(lc_r);
        out_centroid_x     <= cen_r[0];
        out_centroid_y     <= cen_r[1];
        out_centroid_z     <= cen_r[2];
        out_cell_volume    <= vol_out(h_abs);
        out_was_negative   <= h_neg;
        out_negative_total <= neg_cnt_nxt;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without work in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && lc_ok_in && (in_action != ACT_INTERIOR || rc_ok_in)) |=> busy)
    else $error("accepted item did not start");

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (neg_cnt_r >= $past(neg_cnt_r)))
    else $error("negative counter went down");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy)
    else $error("store written while idle");

endmodule
